// ----- sv/thr_pkg.sv -----
// shared types and codes for the timestamped history ring
package thr_pkg;

  typedef enum logic [1:0] {
    REQ_RESET = 2'd0,
    REQ_SET   = 2'd1,
    REQ_NEAR  = 2'd2,
    REQ_COPY  = 2'd3
  } req_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_META   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_COPY   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [63:0] pos_xy;
    logic [31:0] pos_z;
    logic [63:0] vel_xy;
    logic [31:0] vel_z;
    logic [63:0] mov_xy;
    logic [63:0] dir_xy;
    logic [31:0] dir_z;
  } payload_t;

  localparam int STAMP_W = 32;
  localparam int PAY_W   = $bits(payload_t);

endpackage

// ----- sv/thr_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module thr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/timestamped_history_ring_top.sv -----
// timestamped history ring: per-object ring of motion records held in block ram
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  request   in_req_type .. in_dir_z        beat taken when start && !busy
//  result    out_result_index .. out_dir_z  one-cycle beat marked by out_valid
//
// a reset request gives no result
// a copy request passes through ST_META and ST_COPY; set and nearest pass through
//   ST_META, ST_SCAN and ST_FINISH, where the stamp ram's single read port scans
//   the valid entries in the slot (at most LOG_DEPTH-1) one entry per cycle, with
//   the compare working on the stamp read in the previous cycle
// the result beat comes as busy falls, so busy is already low during it
// after rst_n a clearing pass zeroes the ring bookkeeping ram one slot at a time;
//   busy stays high during it
// the receiver cannot stall; results are never held back
module timestamped_history_ring_top #(
  parameter int OBJECT_SLOTS = 64,
  parameter int LOG_DEPTH    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_timestamp,
  input  logic [2:0]  in_entry_index,
  input  logic [63:0] in_pos_xy,
  input  logic [31:0] in_pos_z,
  input  logic [63:0] in_vel_xy,
  input  logic [31:0] in_vel_z,
  input  logic [63:0] in_mov_xy,
  input  logic [63:0] in_dir_xy,
  input  logic [31:0] in_dir_z,
  output logic        out_valid,
  output logic [2:0]  out_result_index,
  output logic        out_rejected,
  output logic [31:0] out_timestamp,
  output logic [63:0] out_pos_xy,
  output logic [31:0] out_pos_z,
  output logic [63:0] out_vel_xy,
  output logic [31:0] out_vel_z,
  output logic [63:0] out_mov_xy,
  output logic [63:0] out_dir_xy,
  output logic [31:0] out_dir_z
);

  import thr_pkg::*;

  localparam int MSLOT_W = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
  localparam int IDX_W   = $clog2(LOG_DEPTH);
  localparam int ENTRIES = OBJECT_SLOTS * LOG_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int META_W  = 2 * IDX_W;

  // slot numbers beyond the slot count fold back; 64-entry constant table
  function automatic logic [MSLOT_W-1:0] fold_slot(input logic [5:0] s);
    logic [MSLOT_W-1:0] r;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      if (s == 6'(k)) r = MSLOT_W'(k % OBJECT_SLOTS);
    end
    return r;
  endfunction

  // entry index folded into the ring length; 8-entry constant table
  function automatic logic [IDX_W-1:0] fold_entry(input logic [2:0] e);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (e == 3'(k)) r = IDX_W'(k % LOG_DEPTH);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(LOG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [MSLOT_W-1:0] s,
                                                 input logic [IDX_W-1:0] p);
    return ADDR_W'(s) * ADDR_W'(LOG_DEPTH) + ADDR_W'(p);
  endfunction

  // low three bits of a ring position, zero-extended for short rings
  function automatic logic [2:0] to_res(input logic [IDX_W-1:0] p);
    logic [IDX_W+2:0] w;
    w = (IDX_W + 3)'(p);
    return w[2:0];
  endfunction

  // control state
  state_t              state_r, state_nxt;
  logic [MSLOT_W-1:0]  clr_r, clr_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic                out_valid_r, out_valid_nxt;

  // request and scan bookkeeping
  req_t                req_r, req_nxt;
  logic [STAMP_W-1:0]  ts_r, ts_nxt;
  logic [MSLOT_W-1:0]  slot_r, slot_nxt;
  logic [IDX_W-1:0]    entry_r, entry_nxt;
  payload_t            pay_r, pay_nxt;
  logic [IDX_W-1:0]    start_r, start_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    piss_r, piss_nxt;
  logic [IDX_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic [IDX_W-1:0]    rd_p_r, rd_p_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_p_r, hit_p_nxt;
  logic                gt_r, gt_nxt;
  logic                stop_r, stop_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt;

  // result registers
  logic [2:0]          res_idx_r, res_idx_nxt;
  logic                rej_r, rej_nxt;
  logic [STAMP_W-1:0]  ots_r, ots_nxt;
  payload_t            opay_r, opay_nxt;

  // ram ports
  logic                meta_we, meta_re;
  logic [MSLOT_W-1:0]  meta_waddr, meta_raddr;
  logic [META_W-1:0]   meta_wdata, meta_rdata;
  logic                dat_we, dat_re;
  logic [ADDR_W-1:0]   dat_waddr, dat_raddr;
  logic [STAMP_W-1:0]  stamp_rdata;
  logic [PAY_W-1:0]    pay_rdata;

  // append position and ring-full test
  logic [IDX_W:0]      app_sum;
  logic [IDX_W-1:0]    app_p;
  logic                ring_full;
  logic                stamp_eq, stamp_gt;

  assign app_sum   = {1'b0, start_r} + {1'b0, cnt_r};
  assign app_p     = (app_sum >= (IDX_W + 1)'(LOG_DEPTH)) ?
                     IDX_W'(app_sum - (IDX_W + 1)'(LOG_DEPTH)) : IDX_W'(app_sum);
  assign ring_full = (cnt_r == IDX_W'(LOG_DEPTH - 1));
  assign stamp_eq  = (stamp_rdata == ts_r);
  assign stamp_gt  = (stamp_rdata > ts_r);

  // ring start and count per slot
  thr_ram #(.WIDTH(META_W), .DEPTH(OBJECT_SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // timestamps, scanned one per cycle
  thr_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (ts_r),
    .re    (dat_re),
    .raddr (dat_raddr),
    .rdata (stamp_rdata)
  );

  // opaque motion payload, same addressing as the stamps
  thr_ram #(.WIDTH(PAY_W), .DEPTH(ENTRIES)) u_pay_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (pay_r),
    .re    (dat_re),
    .raddr (dat_raddr),
    .rdata (pay_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    rd_v_nxt      = rd_v_r;
    out_valid_nxt = 1'b0;
    req_nxt       = req_r;
    ts_nxt        = ts_r;
    slot_nxt      = slot_r;
    entry_nxt     = entry_r;
    pay_nxt       = pay_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    piss_nxt      = piss_r;
    iss_cnt_nxt   = iss_cnt_r;
    rd_p_nxt      = rd_p_r;
    hit_nxt       = hit_r;
    hit_p_nxt     = hit_p_r;
    gt_nxt        = gt_r;
    stop_nxt      = stop_r;
    best_nxt      = best_r;
    res_idx_nxt   = res_idx_r;
    rej_nxt       = rej_r;
    ots_nxt       = ots_r;
    opay_nxt      = opay_r;

    meta_we    = 1'b0;
    meta_waddr = slot_r;
    meta_wdata = '0;
    meta_re    = 1'b0;
    meta_raddr = fold_slot(in_slot);
    dat_we     = 1'b0;
    dat_waddr  = ent_addr(slot_r, app_p);
    dat_re     = 1'b0;
    dat_raddr  = ent_addr(slot_r, piss_r);

    unique case (state_r)
      // zero the per-slot bookkeeping, one slot per cycle
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == MSLOT_W'(OBJECT_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // take a request beat and start the bookkeeping read
      ST_IDLE: begin
        if (start) begin
          meta_re   = 1'b1;
          req_nxt   = req_t'(in_req_type);
          ts_nxt    = in_timestamp;
          slot_nxt  = fold_slot(in_slot);
          entry_nxt = fold_entry(in_entry_index);
          pay_nxt   = '{pos_xy: in_pos_xy, pos_z: in_pos_z, vel_xy: in_vel_xy,
                        vel_z: in_vel_z, mov_xy: in_mov_xy, dir_xy: in_dir_xy,
                        dir_z: in_dir_z};
          state_nxt = ST_META;
        end
      end

      // ring start and count are back from the ram
      ST_META: begin
        start_nxt = meta_rdata[META_W-1:IDX_W];
        cnt_nxt   = meta_rdata[IDX_W-1:0];
        unique case (req_r) inside
          REQ_RESET: begin
            meta_we   = 1'b1;
            state_nxt = ST_IDLE;
          end
          REQ_COPY: begin
            dat_re    = 1'b1;
            dat_raddr = ent_addr(slot_r, entry_r);
            state_nxt = ST_COPY;
          end
          REQ_SET, REQ_NEAR: begin
            piss_nxt    = meta_rdata[META_W-1:IDX_W];
            best_nxt    = meta_rdata[META_W-1:IDX_W];
            iss_cnt_nxt = '0;
            rd_v_nxt    = 1'b0;
            hit_nxt     = 1'b0;
            gt_nxt      = 1'b0;
            stop_nxt    = 1'b0;
            state_nxt   = ST_SCAN;
          end
        endcase
      end

      // read oldest to newest; compare works on the stamp read in the previous cycle
      ST_SCAN: begin
        if (iss_cnt_r != cnt_r) begin
          dat_re      = 1'b1;
          piss_nxt    = ring_inc(piss_r);
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          rd_v_nxt    = 1'b1;
          rd_p_nxt    = piss_r;
        end else begin
          rd_v_nxt = 1'b0;
        end
        if (rd_v_r) begin
          if (stamp_eq && !hit_r) begin
            hit_nxt   = 1'b1;
            hit_p_nxt = rd_p_r;
          end
          gt_nxt = stamp_gt;
          if (!stop_r) begin
            if (stamp_gt) begin
              stop_nxt = 1'b1;
            end else begin
              best_nxt = rd_p_r;
            end
          end
        end
        if (iss_cnt_r == cnt_r && !rd_v_r) begin
          state_nxt = ST_FINISH;
        end
      end

      // write back a set that is taken and raise the result beat
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        rej_nxt       = 1'b0;
        ots_nxt       = '0;
        opay_nxt      = '0;
        if (req_r == REQ_NEAR) begin
          res_idx_nxt = to_res(best_r);
        end else if (hit_r) begin
          // same timestamp already held: refresh its payload
          dat_we      = 1'b1;
          dat_waddr   = ent_addr(slot_r, hit_p_r);
          res_idx_nxt = to_res(hit_p_r);
        end else if (cnt_r != '0 && gt_r) begin
          // older than the newest entry
          rej_nxt     = 1'b1;
          res_idx_nxt = '0;
        end else begin
          dat_we      = 1'b1;
          res_idx_nxt = to_res(app_p);
          meta_we     = 1'b1;
          meta_wdata  = ring_full ? {ring_inc(start_r), cnt_r}
                                  : {start_r, cnt_r + 1'b1};
        end
        state_nxt = ST_IDLE;
      end

      ST_COPY: begin
        out_valid_nxt = 1'b1;
        res_idx_nxt   = to_res(entry_r);
        rej_nxt       = 1'b0;
        ots_nxt       = stamp_rdata;
        opay_nxt      = payload_t'(pay_rdata);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ts_r      <= ts_nxt;
    slot_r    <= slot_nxt;
    entry_r   <= entry_nxt;
    pay_r     <= pay_nxt;
    start_r   <= start_nxt;
    cnt_r     <= cnt_nxt;
    piss_r    <= piss_nxt;
    iss_cnt_r <= iss_cnt_nxt;
    rd_p_r    <= rd_p_nxt;
    hit_r     <= hit_nxt;
    hit_p_r   <= hit_p_nxt;
    gt_r      <= gt_nxt;
    stop_r    <= stop_nxt;
    best_r    <= best_nxt;
    res_idx_r <= res_idx_nxt;
    rej_r     <= rej_nxt;
    ots_r     <= ots_nxt;
    opay_r    <= opay_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_index = res_idx_r;
  assign out_rejected     = rej_r;
  assign out_timestamp    = ots_r;
  assign out_pos_xy       = opay_r.pos_xy;
  assign out_pos_z        = opay_r.pos_z;
  assign out_vel_xy       = opay_r.vel_xy;
  assign out_vel_z        = opay_r.vel_z;
  assign out_mov_xy       = opay_r.mov_xy;
  assign out_dir_xy       = opay_r.dir_xy;
  assign out_dir_z        = opay_r.dir_z;

endmodule

// ----- sv/thr_checker.sv -----
// port-level checks for the timestamped history ring, bound to the top level
module thr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_rejected,
  input logic [2:0]  out_result_index,
  input logic [31:0] out_timestamp
);

  import thr_pkg::*;

  // a beat taken is never answered in the very next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("result beat right after a request beat");

  // one request at a time, so result beats never touch
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // results appear only once the block has gone idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // a rejected set carries position zero and no copied stamp
  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_result_index == 3'd0 && out_timestamp == 32'd0)
    else $error("rejected result with nonzero fields");

  // a ring reset raises busy, then drops it again and gives no result
  a_reset_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_RESET |=> busy ##1 (!busy && !out_valid))
    else $error("ring reset did not complete silently");

endmodule

bind timestamped_history_ring_top thr_checker u_thr_checker (.*);
